>>> hdl/assert_macros.svh
// Assertion helpers, included by rgbss_ctrl.
// Both forms sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge.
`define AST_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: check failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define AST_ALWAYS(lbl, expr)
`define AST_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/rgbss_pkg.sv
package rgbss_pkg;

  // Window geometry.
  localparam int MAX_OFFSET = 15;
  localparam int WIN_DEPTH  = 2 * MAX_OFFSET + 1;
  localparam int AW         = $clog2(WIN_DEPTH);
  localparam int MEM_DEPTH  = 1 << AW;
  localparam int CNT_W      = $clog2(WIN_DEPTH + 1);

  // Field widths.
  localparam int PIX_W = 16;
  localparam int RED_W = 5;
  localparam int GRN_W = 6;
  localparam int BLU_W = 5;
  localparam int OFF_W = 4;
  localparam int PCT_W = 7;

  localparam int RED_MAX = (1 << RED_W) - 1;
  localparam int GRN_MAX = (1 << GRN_W) - 1;
  localparam int BLU_MAX = (1 << BLU_W) - 1;

  // Dimming arithmetic: divide by 100 through a reciprocal multiply.
  localparam int PCT_FULL  = 100;
  localparam int PROD_W    = GRN_W + PCT_W;
  localparam int DIV_SHIFT = 20;
  localparam int DIV_RECIP = (2 ** DIV_SHIFT + PCT_FULL - 1) / PCT_FULL;
  localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
  localparam int SCL_W     = PROD_W + RECIP_W;
  localparam int QUO_W     = SCL_W - DIV_SHIFT;

  // Configuration registers.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_PERCENT  = 1'b1;
  localparam logic [OFF_W-1:0]     SPLIT_OFFSET_RST = 4'd0;
  localparam logic [PCT_W-1:0]     DIM_PERCENT_RST  = 7'd78;

  // Window request from the sequencer: one write and three channel reads.
  typedef struct packed {
    logic             we;
    logic [AW-1:0]    waddr;
    logic [PIX_W-1:0] wdata;
    logic             rd;
    logic [AW-1:0]    addr_red;
    logic [AW-1:0]    addr_grn;
    logic [AW-1:0]    addr_blu;
    logic             last;
    logic             odd;
  } win_req_t;

  // Gathered channels on their way to the dimming stages.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             odd;
    logic [RED_W-1:0] red;
    logic [GRN_W-1:0] grn;
    logic [BLU_W-1:0] blu;
  } chan_t;

  // The framebuffer format holds RGB565 with its two bytes exchanged.
  function automatic logic [PIX_W-1:0] swap_bytes(input logic [PIX_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

>>> hdl/rgbss_ctrl.sv
`include "assert_macros.svh"

module rgbss_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rgbss_pkg::PIX_W-1:0]   in_tdata,
  input  logic                          in_tlast,
  input  logic                          in_tuser,
  input  logic [rgbss_pkg::OFF_W-1:0]   split_offset,
  input  logic                          issue_ready,
  output rgbss_pkg::win_req_t           req
);
  import rgbss_pkg::*;

  logic [AW-1:0]    wp_r, wp_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] ncol_r, ncol_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic             odd_r, odd_nxt;
  logic             busy_r, busy_nxt;
  logic             drain_r, drain_nxt;

  logic             step_acc, step_busy, step, emit;
  logic             mode_drain, line_done, odd_use;
  logic [CNT_W-1:0] off_eff, pend_in, pend_left, dg, newest;
  logic [CNT_W-1:0] rd_raw, rd_dist, bd_dist;
  logic [AW-1:0]    base;

  // Input is taken only when no held pixels are owed to the output.
  assign in_tready = issue_ready && !busy_r;
  assign step_acc  = in_tvalid && in_tready;
  assign step_busy = busy_r && issue_ready;
  assign step      = step_acc || step_busy;

  // Distances of the three sources from the newest held pixel.
  always_comb begin
    off_eff = (CNT_W'(split_offset) > CNT_W'(MAX_OFFSET)) ? CNT_W'(MAX_OFFSET)
                                                          : CNT_W'(split_offset);
    pend_in    = step_acc ? pend_r + CNT_W'(1) : pend_r;
    emit       = step_busy || (step_acc && (pend_in > off_eff || in_tlast));
    pend_left  = pend_in - CNT_W'(emit);
    dg         = pend_in - CNT_W'(1);
    newest     = step_acc ? col_r : ncol_r;
    rd_raw     = dg + off_eff;
    rd_dist    = (rd_raw > newest) ? newest : rd_raw;
    bd_dist    = (dg >= off_eff) ? dg - off_eff : '0;
    base       = step_acc ? wp_r : wp_r - AW'(1);
    mode_drain = step_acc ? in_tlast : drain_r;
    line_done  = emit && mode_drain && (pend_left == '0);
    odd_use    = (step_acc && in_tuser) ? 1'b0 : odd_r;
  end

  // Request to the window memories.
  always_comb begin
    req.we       = step_acc;
    req.waddr    = wp_r;
    req.wdata    = in_tdata;
    req.rd       = emit;
    req.addr_red = base - rd_dist[AW-1:0];
    req.addr_grn = base - dg[AW-1:0];
    req.addr_blu = base - bd_dist[AW-1:0];
    req.last     = line_done;
    req.odd      = odd_use;
  end

  // Line and row bookkeeping.
  always_comb begin
    wp_nxt    = wp_r;
    col_nxt   = col_r;
    ncol_nxt  = ncol_r;
    pend_nxt  = pend_r;
    odd_nxt   = odd_r;
    busy_nxt  = busy_r;
    drain_nxt = drain_r;
    if (step) begin
      pend_nxt  = pend_left;
      drain_nxt = mode_drain;
      busy_nxt  = mode_drain ? (pend_left != '0) : (pend_left > off_eff);
      odd_nxt   = odd_use ^ line_done;
    end
    if (step_acc) begin
      wp_nxt   = wp_r + AW'(1);
      ncol_nxt = col_r;
      if (in_tlast) begin
        col_nxt = '0;
      end else if (col_r < CNT_W'(WIN_DEPTH)) begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      col_r   <= '0;
      ncol_r  <= '0;
      pend_r  <= '0;
      odd_r   <= 1'b0;
      busy_r  <= 1'b0;
      drain_r <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      col_r   <= col_nxt;
      ncol_r  <= ncol_nxt;
      pend_r  <= pend_nxt;
      odd_r   <= odd_nxt;
      busy_r  <= busy_nxt;
      drain_r <= drain_nxt;
    end
  end

  // The number of held pixels never exceeds the largest offset.
  `AST_ALWAYS(a_pend_bound, pend_r <= CNT_W'(MAX_OFFSET))
  // Input is only held off by busy while something is still owed.
  `AST_ALWAYS(a_busy_pend, !busy_r || pend_r != '0)
  // The last drained pixel frees the input and leaves the column count at zero.
  `AST_NEXT(a_drain_exit, step_busy && drain_r && pend_r == CNT_W'(1), !busy_r && col_r == '0)

endmodule

>>> hdl/rgbss_win.sv
module rgbss_win (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbss_pkg::win_req_t req,
  output logic                issue_ready,
  input  logic                dim_ready,
  output rgbss_pkg::chan_t    s1
);
  import rgbss_pkg::*;

  // One narrow memory per channel, each with its own read address.
  logic [RED_W-1:0] mem_red_r [MEM_DEPTH];
  logic [GRN_W-1:0] mem_grn_r [MEM_DEPTH];
  logic [BLU_W-1:0] mem_blu_r [MEM_DEPTH];

  logic [PIX_W-1:0] wsw;
  logic [RED_W-1:0] w_red, q_red_r, wd_red_r;
  logic [GRN_W-1:0] w_grn, q_grn_r, wd_grn_r;
  logic [BLU_W-1:0] w_blu, q_blu_r, wd_blu_r;
  logic             byp_red_r, byp_grn_r, byp_blu_r;
  logic             s1_v_r, s1_last_r, s1_odd_r;
  logic             en1;

  assign en1         = !s1_v_r || dim_ready;
  assign issue_ready = en1;

  // Split the incoming pixel into its channels.
  assign wsw   = swap_bytes(req.wdata);
  assign w_red = wsw[PIX_W-1 -: RED_W];
  assign w_grn = wsw[BLU_W +: GRN_W];
  assign w_blu = wsw[BLU_W-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_red_r[req.waddr] <= w_red;
      mem_grn_r[req.waddr] <= w_grn;
      mem_blu_r[req.waddr] <= w_blu;
    end
  end

  // Registered reads; a read of the entry written in the same cycle
  // takes the new pixel instead.
  always_ff @(posedge clk) begin
    if (en1) begin
      q_red_r   <= mem_red_r[req.addr_red];
      q_grn_r   <= mem_grn_r[req.addr_grn];
      q_blu_r   <= mem_blu_r[req.addr_blu];
      byp_red_r <= req.we && (req.waddr == req.addr_red);
      byp_grn_r <= req.we && (req.waddr == req.addr_grn);
      byp_blu_r <= req.we && (req.waddr == req.addr_blu);
      wd_red_r  <= w_red;
      wd_grn_r  <= w_grn;
      wd_blu_r  <= w_blu;
      s1_last_r <= req.last;
      s1_odd_r  <= req.odd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= req.rd;
    end
  end

  always_comb begin
    s1.valid = s1_v_r;
    s1.last  = s1_last_r;
    s1.odd   = s1_odd_r;
    s1.red   = byp_red_r ? wd_red_r : q_red_r;
    s1.grn   = byp_grn_r ? wd_grn_r : q_grn_r;
    s1.blu   = byp_blu_r ? wd_blu_r : q_blu_r;
  end

endmodule

>>> hdl/rgbss_dim.sv
module rgbss_dim (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rgbss_pkg::chan_t            s1,
  input  logic [rgbss_pkg::PCT_W-1:0] dim_percent,
  output logic                        dim_ready,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rgbss_pkg::PIX_W-1:0] out_tdata,
  output logic                        out_tlast
);
  import rgbss_pkg::*;

  logic [PCT_W-1:0]  factor;
  logic [PROD_W-1:0] prod_red_r, prod_grn_r, prod_blu_r;
  logic              s2_v_r, s2_last_r;
  logic              out_valid_r, out_last_r;
  logic [PIX_W-1:0]  out_pixel_r, out_pixel_nxt;
  logic [GRN_W-1:0]  q_red, q_grn, q_blu;
  logic              en2, en3;

  // Divide by 100 with a reciprocal multiply, then clip to the channel top.
  function automatic logic [GRN_W-1:0] scale(input logic [PROD_W-1:0] p,
                                             input logic [GRN_W-1:0]  top);
    logic [SCL_W-1:0] full;
    logic [QUO_W-1:0] quo;
    full = SCL_W'(p) * SCL_W'(DIV_RECIP);
    quo  = full[SCL_W-1:DIV_SHIFT];
    return (quo > QUO_W'(top)) ? top : quo[GRN_W-1:0];
  endfunction

  assign en3       = !out_valid_r || out_tready;
  assign en2       = !s2_v_r || en3;
  assign dim_ready = en2;

  // Even rows multiply by the full percentage, which leaves a channel as it is.
  assign factor = s1.odd ? dim_percent : PCT_W'(PCT_FULL);

  always_ff @(posedge clk) begin
    if (en2) begin
      prod_red_r <= PROD_W'(s1.red) * PROD_W'(factor);
      prod_grn_r <= PROD_W'(s1.grn) * PROD_W'(factor);
      prod_blu_r <= PROD_W'(s1.blu) * PROD_W'(factor);
      s2_last_r  <= s1.last;
    end
  end

  // Scaled channels repacked into the byte-swapped format.
  always_comb begin
    q_red         = scale(prod_red_r, GRN_W'(RED_MAX));
    q_grn         = scale(prod_grn_r, GRN_W'(GRN_MAX));
    q_blu         = scale(prod_blu_r, GRN_W'(BLU_MAX));
    out_pixel_nxt = swap_bytes({q_red[RED_W-1:0], q_grn, q_blu[BLU_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_pixel_r <= out_pixel_nxt;
      out_last_r  <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en2) begin
        s2_v_r <= s1.valid;
      end
      if (en3) begin
        out_valid_r <= s2_v_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hdl/rgb565_channel_split_scanline.sv
// Channel  Ports           Payload
// in       in_t*           tdata: pixel_in[15:0]; tlast: line_end; tuser: frame_start
// out      out_t*          tdata: pixel_out[15:0]; tlast: line_last
// cfg      cfg_*           index 0: split_offset[3:0]; index 1: dim_percent[6:0]
//
// One pixel per clock in steady state unless the output stalls; a result is
// registered at the window read, then the products, then the output register.
// At a line end, and after the offset shrinks, the held pixels leave one per
// cycle through the shared window read unless the output stalls; input waits.
// Reset is synchronous, active low; it clears the counters and the pipeline
// valid bits and takes no clearing pass over the window memories.
// A stalled output holds all stages behind it; empty stages close up first.
module rgb565_channel_split_scanline (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rgbss_pkg::PIX_W-1:0]      in_tdata,   // [15:0] pixel_in
  input  logic                             in_tlast,
  input  logic                             in_tuser,   // [0] frame_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rgbss_pkg::PIX_W-1:0]      out_tdata,  // [15:0] pixel_out
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgbss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rgbss_pkg::*;

  logic [OFF_W-1:0] split_offset_r;
  logic [PCT_W-1:0] dim_percent_r;
  win_req_t         req;
  chan_t            s1;
  logic             issue_ready, dim_ready;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_offset_r <= SPLIT_OFFSET_RST;
      dim_percent_r  <= DIM_PERCENT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPLIT_OFFSET: split_offset_r <= cfg_data[OFF_W-1:0];
        REG_DIM_PERCENT:  dim_percent_r  <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: line counters and window addressing.
  rgbss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .in_tuser     (in_tuser),
    .split_offset (split_offset_r),
    .issue_ready  (issue_ready),
    .req          (req)
  );

  // Pixel window and channel gather.
  rgbss_win u_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .issue_ready (issue_ready),
    .dim_ready   (dim_ready),
    .s1          (s1)
  );

  // Scanline dimming and output register.
  rgbss_dim u_dim (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1          (s1),
    .dim_percent (dim_percent_r),
    .dim_ready   (dim_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
